// ===== rtl/core/esd_pkg.sv =====
// shared types and constants for the escape sequence decoder
`default_nettype none

package esd_pkg;

    localparam int FIFO_DEPTH = 2;

    localparam logic [2:0] ST_BYTE  = 3'd0;
    localparam logic [2:0] ST_OK    = 3'd1;
    localparam logic [2:0] ST_NONPR = 3'd2;
    localparam logic [2:0] ST_INCOM = 3'd3;
    localparam logic [2:0] ST_INVAL = 3'd4;

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TILDE  = 8'h7E;

    typedef struct packed {
        logic       is_end;
        logic [7:0] ch;
        logic       printable;
        logic       is_bslash;
        logic       is_x;
        logic       simple_valid;
        logic [7:0] simple_val;
        logic       hex_valid;
        logic [3:0] hex_val;
    } class_t;

endpackage

`default_nettype wire

// ===== rtl/core/esd_front.sv =====
// front end: classifies each incoming request
`default_nettype none

module esd_front (
    input  wire logic [7:0]     in_byte,
    input  wire logic           end_of_string,
    output esd_pkg::class_t     cls
);

    logic [7:0] diff;

    always_comb
    begin
        diff             = 8'h00;
        cls.is_end       = end_of_string;
        cls.ch           = in_byte;
        cls.printable    = (in_byte >= esd_pkg::CH_SPACE) && (in_byte <= esd_pkg::CH_TILDE);
        cls.is_bslash    = (in_byte == esd_pkg::CH_BSLASH);
        cls.is_x         = (in_byte == esd_pkg::CH_X);
        cls.simple_valid = 1'b1;
        case (in_byte)
            8'h61:   cls.simple_val = 8'h07;
            8'h62:   cls.simple_val = 8'h08;
            8'h66:   cls.simple_val = 8'h0C;
            8'h6E:   cls.simple_val = 8'h0A;
            8'h72:   cls.simple_val = 8'h0D;
            8'h74:   cls.simple_val = 8'h09;
            8'h76:   cls.simple_val = 8'h0B;
            8'h5C:   cls.simple_val = 8'h5C;
            8'h27:   cls.simple_val = 8'h27;
            8'h22:   cls.simple_val = 8'h22;
            default:
            begin
                cls.simple_val   = 8'h00;
                cls.simple_valid = 1'b0;
            end
        endcase
        cls.hex_valid = 1'b1;
        if (in_byte inside {[8'h30:8'h39]})
        begin
            diff = in_byte - 8'h30;
        end
        else if (in_byte inside {[8'h41:8'h46]})
        begin
            diff = in_byte - 8'h37;
        end
        else if (in_byte inside {[8'h61:8'h66]})
        begin
            diff = in_byte - 8'h57;
        end
        else
        begin
            cls.hex_valid = 1'b0;
        end
        cls.hex_val = diff[3:0];
    end

endmodule

`default_nettype wire

// ===== rtl/core/esd_fifo.sv =====
// short queue of classified requests between front and back
`default_nettype none

module esd_fifo #(
    parameter int DEPTH = esd_pkg::FIFO_DEPTH
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push_valid,
    output logic                 push_ready,
    input  wire esd_pkg::class_t push_data,
    output logic                 pop_valid,
    input  wire logic            pop_ready,
    output esd_pkg::class_t      pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    esd_pkg::class_t  mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/esd_back.sv =====
// back end: escape state machine and output register
`default_nettype none

module esd_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cls_valid,
    output logic                 cls_ready,
    input  wire esd_pkg::class_t cls,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output logic [7:0]           out_byte,
    output logic [2:0]           status,
    output logic                 last
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_ESC,
        PH_HEX1,
        PH_HEX2,
        PH_DROP
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [3:0] nib_reg, nib_next;
    logic       nib_ok_reg, nib_ok_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic [2:0] status_reg, status_next;
    logic       last_reg, last_next;
    logic       pop, emit;
    logic [7:0] e_byte;
    logic [2:0] e_st;

    assign cls_ready = !out_valid_reg || out_ready;
    assign pop       = cls_valid && cls_ready;
    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign status    = status_reg;
    assign last      = last_reg;

    always_comb
    begin
        phase_next     = phase_reg;
        nib_next       = nib_reg;
        nib_ok_next    = nib_ok_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_byte_next  = out_byte_reg;
        status_next    = status_reg;
        last_next      = last_reg;
        emit           = 1'b0;
        e_byte         = 8'h00;
        e_st           = esd_pkg::ST_BYTE;
        if (pop)
        begin
            if (cls.is_end)
            begin
                phase_next  = PH_IDLE;
                nib_next    = 4'h0;
                nib_ok_next = 1'b0;
                if (phase_reg == PH_IDLE)
                begin
                    emit = 1'b1;
                    e_st = esd_pkg::ST_OK;
                end
                else if (phase_reg != PH_DROP)
                begin
                    emit = 1'b1;
                    e_st = esd_pkg::ST_INCOM;
                end
            end
            else
            begin
                case (phase_reg)
                    PH_DROP:
                    begin
                        phase_next = PH_DROP;
                    end
                    PH_ESC:
                    begin
                        if (cls.is_x)
                        begin
                            phase_next = PH_HEX1;
                        end
                        else if (cls.simple_valid)
                        begin
                            emit       = 1'b1;
                            e_byte     = cls.simple_val;
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            emit       = 1'b1;
                            e_st       = esd_pkg::ST_INVAL;
                            phase_next = PH_DROP;
                        end
                    end
                    PH_HEX1:
                    begin
                        nib_next    = cls.hex_val;
                        nib_ok_next = cls.hex_valid;
                        phase_next  = PH_HEX2;
                    end
                    PH_HEX2:
                    begin
                        emit = 1'b1;
                        if (!nib_ok_reg || !cls.hex_valid || ({nib_reg, cls.hex_val} == 8'h00))
                        begin
                            e_st       = esd_pkg::ST_INVAL;
                            phase_next = PH_DROP;
                        end
                        else
                        begin
                            e_byte      = {nib_reg, cls.hex_val};
                            phase_next  = PH_IDLE;
                            nib_next    = 4'h0;
                            nib_ok_next = 1'b0;
                        end
                    end
                    default:
                    begin
                        if (!cls.printable)
                        begin
                            emit       = 1'b1;
                            e_st       = esd_pkg::ST_NONPR;
                            phase_next = PH_DROP;
                        end
                        else if (cls.is_bslash)
                        begin
                            phase_next = PH_ESC;
                        end
                        else
                        begin
                            emit       = 1'b1;
                            e_byte     = cls.ch;
                            phase_next = PH_IDLE;
                        end
                    end
                endcase
            end
            if (emit)
            begin
                out_valid_next = 1'b1;
                out_byte_next  = e_byte;
                status_next    = e_st;
                last_next      = (e_st != esd_pkg::ST_BYTE);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            nib_reg       <= 4'h0;
            nib_ok_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            out_byte_reg  <= 8'h00;
            status_reg    <= esd_pkg::ST_BYTE;
            last_reg      <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            nib_reg       <= nib_next;
            nib_ok_reg    <= nib_ok_next;
            out_valid_reg <= out_valid_next;
            out_byte_reg  <= out_byte_next;
            status_reg    <= status_next;
            last_reg      <= last_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/escape_sequence_decoder.sv =====
// top level of the escape sequence decoder
//
// input channel: in_valid/in_ready carry one raw byte per request in in_byte,
//   or an end request with end_of_string high that closes the string
// output channel: out_valid/out_ready carry at most one result per request:
//   out_byte with status, and last high on the result that ends a string
// the front classifies each byte combinationally into a short queue of
//   FIFO_DEPTH entries; the back runs the escape state machine and owns the
//   output register
// the back registers a result when it pops the request from the queue
// throughput: one request per cycle unless a stalled result blocks the back;
//   requests inside an escape or after an error give no result
// when the receiver stalls the output register holds its result, the queue
//   fills, and in_ready falls once it is full
// reset clears the queue, the output register and the escape state
`default_nettype none

module escape_sequence_decoder #(
    parameter int FIFO_DEPTH = esd_pkg::FIFO_DEPTH
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_byte,
    input  wire logic       end_of_string,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic [2:0]      status,
    output logic            last
);

    esd_pkg::class_t front_cls;
    esd_pkg::class_t back_cls;
    logic            q_valid;
    logic            q_ready;

    esd_front u_front (
        .in_byte       (in_byte),
        .end_of_string (end_of_string),
        .cls           (front_cls)
    );

    esd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (in_valid),
        .push_ready (in_ready),
        .push_data  (front_cls),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (back_cls)
    );

    esd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cls_valid (q_valid),
        .cls_ready (q_ready),
        .cls       (back_cls),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .status    (status),
        .last      (last)
    );

endmodule

`default_nettype wire

// ===== rtl/core/esd_checker.sv =====
// port level checks for the escape sequence decoder
`default_nettype none

module esd_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] out_byte,
    input wire logic [2:0] status,
    input wire logic       last
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(status)
            && $stable(last))
        else $error("stalled result changed");

    a_last_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last == (status != esd_pkg::ST_BYTE)))
        else $error("last does not match status");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status <= esd_pkg::ST_INVAL))
        else $error("status code out of range");

    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != esd_pkg::ST_BYTE) |-> (out_byte == 8'h00))
        else $error("byte not zero on a closing result");

endmodule

bind escape_sequence_decoder esd_checker u_esd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .status    (status),
    .last      (last)
);

`default_nettype wire

// ===== bench/tb.sv =====
// self-checking testbench for the escape sequence decoder
`default_nettype none

module tb;

    localparam int HOLD_CYCLES = 80;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_ESC,
        PH_HEX1,
        PH_HEX2,
        PH_DROP
    } esc_phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic [2:0] code;
        logic       fin;
    } decoded_t;

    localparam logic [7:0] ESC_IN [10] = '{8'h61, 8'h62, 8'h66, 8'h6E, 8'h72,
                                           8'h74, 8'h76, 8'h5C, 8'h27, 8'h22};
    localparam logic [7:0] ESC_OUT [10] = '{8'h07, 8'h08, 8'h0C, 8'h0A, 8'h0D,
                                            8'h09, 8'h0B, 8'h5C, 8'h27, 8'h22};

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] in_byte = 8'h00;
    logic       end_of_string = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] out_byte;
    logic [2:0] status;
    logic       last;

    esc_phase_t dec_phase = PH_IDLE;
    logic [4:0] dec_nibble = 5'd0;
    decoded_t   decoded_queue[$];
    logic [7:0] string_buf[$];

    int in_idle_pct = 0;
    int out_stall_pct = 0;
    int hold_serial = 0;
    int hold_taken = 0;
    int hold_left = 0;
    int failures = 0;
    int requests_sent = 0;

    escape_sequence_decoder u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_byte      (in_byte),
        .end_of_string(end_of_string),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_byte     (out_byte),
        .status       (status),
        .last         (last)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39)
        begin
            return 5'(c - 8'h30);
        end
        if (c >= 8'h41 && c <= 8'h46)
        begin
            return 5'(c - 8'h41 + 8'd10);
        end
        if (c >= 8'h61 && c <= 8'h66)
        begin
            return 5'(c - 8'h61 + 8'd10);
        end
        return 5'd16;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
        if (n < 4'd10)
        begin
            return 8'h30 + 8'(n);
        end
        return (upper ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
    endfunction

    function automatic void push_result(input logic [7:0] data, input logic [2:0] code);
        decoded_t r;
        r.data = data;
        r.code = code;
        r.fin  = (code != esd_pkg::ST_BYTE);
        decoded_queue.push_back(r);
    endfunction

    // advances the escape state for one accepted request
    function automatic void decode_char(input logic [7:0] ch, input logic eos);
        logic [4:0] low;
        logic       found;
        logic [7:0] val;
        if (eos)
        begin
            if (dec_phase == PH_IDLE)
            begin
                push_result(8'h00, esd_pkg::ST_OK);
            end
            else if (dec_phase != PH_DROP)
            begin
                push_result(8'h00, esd_pkg::ST_INCOM);
            end
            dec_phase  = PH_IDLE;
            dec_nibble = 5'd0;
            return;
        end
        case (dec_phase)
            PH_DROP:
            begin
            end
            PH_ESC:
            begin
                found = 1'b0;
                val   = 8'h00;
                for (int i = 0; i < 10; i++)
                begin
                    if (ch == ESC_IN[i])
                    begin
                        found = 1'b1;
                        val   = ESC_OUT[i];
                    end
                end
                if (ch == esd_pkg::CH_X)
                begin
                    dec_phase = PH_HEX1;
                end
                else if (found)
                begin
                    push_result(val, esd_pkg::ST_BYTE);
                    dec_phase = PH_IDLE;
                end
                else
                begin
                    push_result(8'h00, esd_pkg::ST_INVAL);
                    dec_phase = PH_DROP;
                end
            end
            PH_HEX1:
            begin
                dec_nibble = hex_digit(ch);
                dec_phase  = PH_HEX2;
            end
            PH_HEX2:
            begin
                low = hex_digit(ch);
                if (dec_nibble[4] || low[4] || {dec_nibble[3:0], low[3:0]} == 8'h00)
                begin
                    push_result(8'h00, esd_pkg::ST_INVAL);
                    dec_phase = PH_DROP;
                end
                else
                begin
                    push_result({dec_nibble[3:0], low[3:0]}, esd_pkg::ST_BYTE);
                    dec_nibble = 5'd0;
                    dec_phase  = PH_IDLE;
                end
            end
            default:
            begin
                if (ch < esd_pkg::CH_SPACE || ch > esd_pkg::CH_TILDE)
                begin
                    push_result(8'h00, esd_pkg::ST_NONPR);
                    dec_phase = PH_DROP;
                end
                else if (ch == esd_pkg::CH_BSLASH)
                begin
                    dec_phase = PH_ESC;
                end
                else
                begin
                    push_result(ch, esd_pkg::ST_BYTE);
                    dec_phase = PH_IDLE;
                end
            end
        endcase
    endfunction

    task automatic send_item(input logic [7:0] b, input logic eos);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        in_byte       <= b;
        end_of_string <= eos;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        decode_char(b, eos);
        requests_sent++;
    endtask

    task automatic send_end();
        send_item(8'($urandom_range(255)), 1'b1);
    endtask

    task automatic send_chars(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_item(s[i], 1'b0);
        end
    endtask

    task automatic send_string_buf();
        foreach (string_buf[i])
        begin
            send_item(string_buf[i], 1'b0);
        end
        send_end();
    endtask

    task automatic release_input();
        in_valid <= 1'b0;
    endtask

    task automatic wait_for_results();
        while (decoded_queue.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (6) @(posedge clk);
    endtask

    task automatic check_result();
        decoded_t want;
        if (decoded_queue.size() == 0)
        begin
            $display("%0t: unexpected result, expected none, actual out_byte %h status %0d last %b",
                     $time, out_byte, status, last);
            failures++;
            return;
        end
        want = decoded_queue.pop_front();
        if (out_byte !== want.data)
        begin
            $display("%0t: out_byte expected %h actual %h", $time, want.data, out_byte);
            failures++;
        end
        if (status !== want.code)
        begin
            $display("%0t: status expected %0d actual %0d", $time, want.code, status);
            failures++;
        end
        if (last !== want.fin)
        begin
            $display("%0t: last expected %b actual %b", $time, want.fin, last);
            failures++;
        end
    endtask

    // receiving side: checks each result
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                check_result();
            end
        end
    end

    // receiver readiness, with a long hold counted in cycles
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_taken != hold_serial)
            begin
                hold_left  = HOLD_CYCLES;
                hold_taken = hold_serial;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= out_stall_pct);
            end
        end
    end

    function automatic void build_random_string();
        int         tokens;
        int         r;
        logic [7:0] c;
        logic [7:0] v;
        string_buf.delete();
        if ($urandom_range(9) == 0)
        begin
            repeat ($urandom_range(1, 8)) string_buf.push_back(8'($urandom_range(255)));
            return;
        end
        tokens = $urandom_range(0, 8);
        for (int t = 0; t < tokens; t++)
        begin
            r = $urandom_range(99);
            if (r < 55)
            begin
                do
                begin
                    c = 8'($urandom_range(32, 126));
                end
                while (c == esd_pkg::CH_BSLASH);
                string_buf.push_back(c);
            end
            else if (r < 72)
            begin
                string_buf.push_back(esd_pkg::CH_BSLASH);
                string_buf.push_back(ESC_IN[$urandom_range(9)]);
            end
            else if (r < 84)
            begin
                v = 8'($urandom_range(1, 255));
                string_buf.push_back(esd_pkg::CH_BSLASH);
                string_buf.push_back(esd_pkg::CH_X);
                string_buf.push_back(hex_char(v[7:4], bit'($urandom_range(1))));
                string_buf.push_back(hex_char(v[3:0], bit'($urandom_range(1))));
            end
            else if (r < 88)
            begin
                if ($urandom_range(1))
                begin
                    string_buf.push_back(8'($urandom_range(0, 31)));
                end
                else
                begin
                    string_buf.push_back(8'($urandom_range(127, 255)));
                end
            end
            else if (r < 93)
            begin
                string_buf.push_back(esd_pkg::CH_BSLASH);
                string_buf.push_back(8'($urandom_range(255)));
            end
            else if (r < 97)
            begin
                string_buf.push_back(esd_pkg::CH_BSLASH);
                string_buf.push_back(esd_pkg::CH_X);
                string_buf.push_back(8'($urandom_range(255)));
                string_buf.push_back(8'($urandom_range(255)));
            end
            else
            begin
                // cut short inside an escape so the end request lands in it
                string_buf.push_back(esd_pkg::CH_BSLASH);
                r = $urandom_range(2);
                if (r > 0)
                begin
                    string_buf.push_back(esd_pkg::CH_X);
                end
                if (r > 1)
                begin
                    string_buf.push_back(8'($urandom_range(255)));
                end
                break;
            end
        end
    endfunction

    task automatic test_plain_and_escapes();
        send_end();
        send_chars(" ~\\a\\b\\f\\n\\r\\t\\v\\\\\\'\\\"");
        send_end();
        send_chars("\\x01\\xFf");
        send_end();
    endtask

    task automatic test_error_cases();
        send_item(8'h00, 1'b0);
        send_chars("A");
        send_end();
        send_item(8'hFF, 1'b0);
        send_end();
        send_chars("\\q");
        send_end();
        send_chars("\\x00");
        send_end();
        send_chars("\\xg1");
        send_end();
        send_chars("\\x1");
        send_end();
        send_chars("\\");
        send_end();
    endtask

    task automatic test_random_strings(input int count, input int idle, input int stall);
        int start;
        in_idle_pct   = idle;
        out_stall_pct = stall;
        start = requests_sent;
        while (requests_sent - start < count)
        begin
            build_random_string();
            send_string_buf();
        end
    endtask

    task automatic test_backpressure();
        in_idle_pct   = 0;
        out_stall_pct = 0;
        hold_serial++;
        for (int i = 0; i < 40; i++)
        begin
            send_item(8'h41 + 8'(i % 26), 1'b0);
        end
        send_end();
        // sender stands back until the queue of results is empty
        release_input();
        wait_for_results();
        send_chars("\\x7e!");
        send_end();
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_plain_and_escapes();
        test_error_cases();
        test_random_strings(375, 0, 0);
        test_random_strings(375, 66, 0);
        test_backpressure();
        test_random_strings(375, 0, 66);
        test_random_strings(375, 25, 25);
        release_input();
        wait_for_results();
        if (decoded_queue.size() != 0)
        begin
            $display("%0t: %0d results expected, actual none", $time, decoded_queue.size());
            failures++;
        end
        if (failures == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial
    begin
        #5000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
